// ===== rtl/core/nsf_pkg.sv =====
// Shared types and constants of the NMEA sentence framer.
`timescale 1ns / 1ps

package nsf_pkg;

	localparam int ID_COUNT = 12;
	localparam int HDR_LEN = 6;
	localparam int HDR_BITS = HDR_LEN * 8;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;

	// Header IDs, first character in the top byte. The order matches the accept mask bits.
	localparam logic [HDR_BITS-1:0] ID_TABLE [ID_COUNT] = '{
		"$GPRMC", "$GNRMC", "$BDRMC",
		"$GPGGA", "$GNGGA", "$BDGGA",
		"$GPVTG", "$GNVTG", "$BDVTG",
		"$GPZDA", "$GNZDA", "$BDZDA"
	};

	typedef struct packed {
		logic       ok;
		logic [3:0] kind;
	} nsf_match_t;

	typedef struct packed {
		logic       store_enable;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic [8:0] line_length;
		logic       sentence_ok;
		logic [3:0] sentence_kind;
	} nsf_result_t;

endpackage

// ===== rtl/core/nsf_hdr_match.sv =====
// Parallel compare of the six header bytes against the twelve sentence IDs.
`timescale 1ns / 1ps

module nsf_hdr_match
	import nsf_pkg::*;
(
	input  logic [HDR_BITS-1:0] header,
	input  logic [ID_COUNT-1:0] mask,
	output nsf_match_t          match
);

	logic [ID_COUNT-1:0] hit;
	logic [ID_COUNT-1:0] gated;
	logic [3:0]          kind;

	always_comb begin
		for (int k = 0; k < ID_COUNT; k++) begin
			hit[k] = (header == ID_TABLE[k]);
		end
		gated = hit & mask;
		// The IDs are distinct, so at most one bit is set.
		kind = '0;
		for (int k = ID_COUNT - 1; k >= 0; k--) begin
			if (gated[k]) begin
				kind = 4'(k);
			end
		end
		match.ok = |gated;
		match.kind = kind;
	end

endmodule

// ===== rtl/core/nsf_line_state.sv =====
// Line state (length, header copy, last stored byte) and the per-byte framing step.
`timescale 1ns / 1ps

module nsf_line_state
	import nsf_pkg::*;
#(
	parameter int LINE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          rx_byte,
	input  logic [ID_COUNT-1:0] mask,
	output nsf_result_t         result
);

	localparam int CW = $clog2(LINE_DEPTH + 1);

	logic [CW-1:0] fill_q;
	logic [7:0]    hdr_q [HDR_LEN];
	logic [7:0]    last_q;

	logic [CW-1:0]       fill_w;
	logic [CW-1:0]       pos;
	logic [CW-1:0]       fill_next;
	logic                is_start;
	logic                is_lf;
	logic                do_put;
	logic [7:0]          hdr_next [HDR_LEN];
	logic [HDR_BITS-1:0] hdr_pack;
	nsf_match_t          match;

	always_comb begin
		// A full line wraps to empty before the byte is looked at.
		fill_w = (fill_q >= CW'(LINE_DEPTH)) ? '0 : fill_q;
		is_start = (rx_byte == CH_START);
		is_lf = (rx_byte == CH_LF);
		do_put = is_start || !is_lf || ((fill_w != '0) && (last_q == CH_CR));
		pos = is_start ? '0 : fill_w;
		fill_next = do_put ? (pos + CW'(1)) : fill_w;
		for (int j = 0; j < HDR_LEN; j++) begin
			hdr_next[j] = (do_put && (pos == CW'(j))) ? rx_byte : hdr_q[j];
			hdr_pack[HDR_BITS-1-8*j -: 8] = hdr_next[j];
		end
	end

	nsf_hdr_match u_match (
		.header (hdr_pack),
		.mask   (mask),
		.match  (match)
	);

	always_comb begin
		result.store_enable = do_put;
		result.store_index = do_put ? 8'(pos) : 8'h00;
		result.store_byte = do_put ? rx_byte : 8'h00;
		result.line_length = 9'(fill_next);
		result.sentence_ok = is_lf && do_put && match.ok;
		result.sentence_kind = (is_lf && do_put && match.ok) ? match.kind : 4'h0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			last_q <= '0;
			for (int j = 0; j < HDR_LEN; j++) begin
				hdr_q[j] <= '0;
			end
		end else if (step_en) begin
			fill_q <= fill_next;
			if (do_put) begin
				last_q <= rx_byte;
			end
			for (int j = 0; j < HDR_LEN; j++) begin
				hdr_q[j] <= hdr_next[j];
			end
		end
	end

endmodule

// ===== rtl/core/nmea_sentence_framer_top.sv =====
// Top level of the NMEA sentence framer: input register, framing step, result register.
`timescale 1ns / 1ps

// The framer takes one received serial character per request on the input
// channel (in_valid / in_ready, payload rx_byte) and returns exactly one result
// request per character on the output channel (out_valid / out_ready): whether
// and where the byte went into the line store, the line length after it, and a
// sentence_ok pulse with sentence_kind when a CR LF ended a line whose header
// matches an ID enabled in accept_mask.
// The accept mask is written through its own channel (cfg_valid / cfg_ready,
// data on accept_mask); cfg_ready is always high. Write it only while idle.
// A character accepted on the input channel is captured in the input register,
// framed, and its result loaded into the result register. Throughput is one
// character per cycle while the receiver does not stall, set by the single framing
// step between the two registers; the line state advances as the result is loaded.
// When the receiver stalls, the result register holds its request unchanged,
// the input register keeps one more character, and in_ready then drops until
// out_ready returns.
// Reset clears the line length, the header copy and the last stored byte, sets
// the accept mask to all ones, and empties both registers.
module nmea_sentence_framer_top
	import nsf_pkg::*;
#(
	parameter int LINE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                store_enable,
	output logic [7:0]          store_index,
	output logic [7:0]          store_byte,
	output logic [8:0]          line_length,
	output logic                sentence_ok,
	output logic [3:0]          sentence_kind,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ID_COUNT-1:0] accept_mask
);

	logic [ID_COUNT-1:0] mask_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                out_valid_q;
	nsf_result_t         res_q;
	nsf_result_t         step_res;
	logic                advance;

	// The framing step runs when the input register holds a character and the
	// result register is free or being emptied in this cycle.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
		end else if (cfg_valid) begin
			mask_q <= accept_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	nsf_line_state #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.rx_byte (byte_s1),
		.mask    (mask_q),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign store_enable = res_q.store_enable;
	assign store_index = res_q.store_index;
	assign store_byte = res_q.store_byte;
	assign line_length = res_q.line_length;
	assign sentence_ok = res_q.sentence_ok;
	assign sentence_kind = res_q.sentence_kind;

endmodule

// ===== rtl/core/nsf_checker.sv =====
// Port-level assertions for the NMEA sentence framer and their bind.
`timescale 1ns / 1ps

module nsf_checker
	import nsf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       store_enable,
	input logic [7:0] store_index,
	input logic [7:0] store_byte,
	input logic [8:0] line_length,
	input logic       sentence_ok,
	input logic [3:0] sentence_kind
);

	// A stalled result request keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(store_index) && $stable(line_length)
			&& $stable(sentence_ok))
		else $error("result changed while stalled");

	// A sentence can only end on a stored line feed.
	a_ok_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sentence_ok |-> store_enable && (store_byte == CH_LF))
		else $error("sentence_ok without a stored line feed");

	// The kind is only reported with the pulse.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sentence_ok |-> sentence_kind == 4'h0)
		else $error("sentence_kind set without sentence_ok");

	// A start character always opens a new line at position zero.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_enable && (store_byte == CH_START)
			|-> (store_index == 8'h00) && (line_length == 9'd1))
		else $error("start character did not restart the line");

	// Nothing is reported as written when the byte was dropped.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !store_enable |-> (store_index == 8'h00) && (store_byte == 8'h00)
			&& !sentence_ok)
		else $error("dropped byte reported a store write");

endmodule

bind nmea_sentence_framer_top nsf_checker u_nsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.store_enable  (store_enable),
	.store_index   (store_index),
	.store_byte    (store_byte),
	.line_length   (line_length),
	.sentence_ok   (sentence_ok),
	.sentence_kind (sentence_kind)
);

// ===== tb/nsf_framer_checker.sv =====
// Checker for the NMEA sentence framer: predicts each result request and compares it.
`timescale 1ns / 1ps

module nsf_framer_checker
	import nsf_pkg::*;
#(
	parameter int LINE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                store_enable,
	input  logic [7:0]          store_index,
	input  logic [7:0]          store_byte,
	input  logic [8:0]          line_length,
	input  logic                sentence_ok,
	input  logic [3:0]          sentence_kind,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [ID_COUNT-1:0] accept_mask,
	output int                  fail_count,
	output int                  pending,
	output int                  checked,
	output int                  sentences
);

	// Shadow of the framer state.
	logic [8:0]          line_len;
	logic [7:0]          hdr [HDR_LEN];
	logic [7:0]          last_char;
	logic [ID_COUNT-1:0] mask_copy;

	nsf_result_t expected_results [$];
	int          errors;
	int          n_checked;
	int          n_sentences;

	// Frames one character against the shadow state and gives its result.
	task automatic frame_char(input logic [7:0] c, output nsf_result_t r);
		logic [HDR_BITS-1:0] hdr_word;
		logic                found;
		r = '0;
		found = 1'b0;
		if (line_len >= LINE_DEPTH)
			line_len = '0;
		if (c == CH_START)
			line_len = '0;
		// A line feed is kept only right after a stored carriage return.
		if (c != CH_LF || (line_len != 0 && last_char == CH_CR)) begin
			r.store_enable = 1'b1;
			r.store_index = line_len[7:0];
			r.store_byte = c;
			if (line_len < HDR_LEN)
				hdr[line_len[2:0]] = c;
			last_char = c;
			line_len = line_len + 9'd1;
			if (c == CH_LF) begin
				hdr_word = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]};
				for (int k = 0; k < ID_COUNT; k++) begin
					if (!found && hdr_word == ID_TABLE[k]) begin
						found = 1'b1;
						if (mask_copy[k]) begin
							r.sentence_ok = 1'b1;
							r.sentence_kind = 4'(k);
						end
					end
				end
			end
		end
		r.line_length = line_len;
	endtask

	task automatic check_field(input string name, input logic [8:0] exp_v, input logic [8:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		nsf_result_t exp_r;
		nsf_result_t got_r;
		if (!arst_n) begin
			line_len = '0;
			last_char = '0;
			mask_copy = '1;
			for (int i = 0; i < HDR_LEN; i++)
				hdr[i] = '0;
			expected_results.delete();
			errors = 0;
			n_checked = 0;
			n_sentences = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
			sentences <= 0;
		end else begin
			// Compare first: a result leaving now never belongs to a character entering now.
			if (out_valid && out_ready) begin
				got_r = {store_enable, store_index, store_byte, line_length,
					sentence_ok, sentence_kind};
				if (expected_results.size() == 0) begin
					$display("%0t: result with no character pending, actual %0h", $time, got_r);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("store_enable", 9'(exp_r.store_enable),
						9'(got_r.store_enable));
					check_field("store_index", 9'(exp_r.store_index), 9'(got_r.store_index));
					check_field("store_byte", 9'(exp_r.store_byte), 9'(got_r.store_byte));
					check_field("line_length", exp_r.line_length, got_r.line_length);
					check_field("sentence_ok", 9'(exp_r.sentence_ok), 9'(got_r.sentence_ok));
					check_field("sentence_kind", 9'(exp_r.sentence_kind),
						9'(got_r.sentence_kind));
					n_checked++;
					if (exp_r.sentence_ok)
						n_sentences++;
				end
			end
			if (in_valid && in_ready) begin
				frame_char(rx_byte, exp_r);
				expected_results.push_back(exp_r);
			end
			if (cfg_valid && cfg_ready)
				mask_copy = accept_mask;
			fail_count <= errors;
			pending <= expected_results.size();
			checked <= n_checked;
			sentences <= n_sentences;
		end
	end

endmodule

// ===== tb/nmea_sentence_framer_top_test.sv =====
// Testbench top for the NMEA sentence framer: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module nmea_sentence_framer_top_test;
	import nsf_pkg::*;

	localparam int LINE_DEPTH = 256;
	// The limit lies far beyond what a correct run needs.
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_CHARS = 250;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          rx_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                store_enable;
	logic [7:0]          store_index;
	logic [7:0]          store_byte;
	logic [8:0]          line_length;
	logic                sentence_ok;
	logic [3:0]          sentence_kind;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [ID_COUNT-1:0] mask_data = '1;

	int fail_count;
	int pending;
	int checked;
	int sentences;

	// Percentages of idle cycles on each side; the receiver stall is read by its own driver.
	int send_idle_pct = 0;
	int stall_pct = 0;
	int chars_sent = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	nmea_sentence_framer_top #(
		.LINE_DEPTH(LINE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.store_enable(store_enable),
		.store_index(store_index),
		.store_byte(store_byte),
		.line_length(line_length),
		.sentence_ok(sentence_ok),
		.sentence_kind(sentence_kind),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.accept_mask(mask_data)
	);

	// The checker watches both channels and the register port; this module only drives.
	nsf_framer_checker #(
		.LINE_DEPTH(LINE_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.store_enable(store_enable),
		.store_index(store_index),
		.store_byte(store_byte),
		.line_length(line_length),
		.sentence_ok(sentence_ok),
		.sentence_kind(sentence_kind),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.accept_mask(mask_data),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked),
		.sentences(sentences)
	);

	// The receiver stalls at random, one decision per cycle, at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung handshake or a result that never comes ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
			$display("** nmea_sentence_framer_top: FAILED **");
			$finish;
		end
	end

	// Offers one character as a request. Idle cycles come before it at the phase rate;
	// valid is only lowered in those gaps, so back-to-back requests keep it high.
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		do
			@(posedge clk);
		while (!in_ready);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Holds the sender until every predicted result has been seen. The first edge lets
	// the checker count a character that was accepted at the edge we returned on.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// Let the pipeline settle before the register is touched.
		repeat (3) @(posedge clk);
	endtask

	task automatic write_mask(input logic [ID_COUNT-1:0] m);
		wait_drained();
		cfg_valid <= 1'b1;
		mask_data <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random chunk of traffic. Most of it is well-formed sentences with a known
	// header (sometimes with one letter altered) and random body text; the rest is raw
	// noise over the full byte range and broken endings. A rare very long body makes
	// the line length run past the store depth and wrap.
	task automatic send_traffic();
		logic [HDR_BITS-1:0] id;
		logic [7:0]          c;
		int                  sel;
		int                  body_len;
		int                  bad_pos;
		sel = $urandom_range(99);
		if (sel < 72) begin
			id = ID_TABLE[$urandom_range(ID_COUNT - 1)];
			bad_pos = ($urandom_range(9) == 0) ? $urandom_range(1, HDR_LEN - 1) : -1;
			for (int i = 0; i < HDR_LEN; i++) begin
				c = id[HDR_BITS - 1 - 8 * i -: 8];
				if (i == bad_pos)
					c = 8'($urandom_range(8'h41, 8'h5a));
				send_char(c);
			end
			body_len = ($urandom_range(29) == 0) ? $urandom_range(250, 300)
				: $urandom_range(0, 24);
			for (int i = 0; i < body_len; i++)
				send_char(8'($urandom_range(8'h20, 8'h7e)));
			case ($urandom_range(9))
				0: send_char(CH_LF);
				1: send_char(CH_CR);
				2: begin
					send_char(CH_CR);
					send_char(CH_CR);
					send_char(CH_LF);
				end
				default: begin
					send_char(CH_CR);
					send_char(CH_LF);
				end
			endcase
		end else if (sel < 88) begin
			repeat ($urandom_range(1, 8))
				send_char(8'($urandom_range(255)));
		end else begin
			case ($urandom_range(3))
				0: send_char(CH_LF);
				1: begin
					send_char(CH_CR);
					send_char(CH_LF);
					send_char(CH_LF);
				end
				2: begin
					send_char(CH_START);
					send_char(CH_CR);
					send_char(CH_LF);
				end
				default: begin
					send_char(CH_START);
					send_char(CH_START);
					send_char(CH_LF);
				end
			endcase
		end
	endtask

	initial begin
		logic [ID_COUNT-1:0] masks [PHASE_COUNT];
		int                  target;

		// Masks per phase: both extremes, alternating patterns and random sets.
		masks[0] = '1;
		masks[1] = '0;
		masks[2] = ID_COUNT'($urandom_range(4095));
		masks[3] = 12'haaa;
		masks[4] = 12'h555;
		masks[5] = ID_COUNT'($urandom_range(4095));
		masks[6] = ID_COUNT'($urandom_range(4095));
		masks[7] = '1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset mask. A line feed on an empty line is dropped,
		// then the byte extremes, then a line feed that follows no carriage return.
		send_char(CH_LF);
		send_char(8'h00);
		send_char(8'hff);
		send_char(CH_LF);
		// A full accepted sentence.
		send_text("$GPRMC");
		send_char(CH_CR);
		send_char(CH_LF);
		// A short line: the header compare sees its own CR and LF in the header slots.
		send_text("$GN");
		send_char(CH_CR);
		send_char(CH_LF);
		// Carriage returns twice, then a line feed without a fresh start byte.
		send_char(CH_CR);
		send_char(CH_CR);
		send_char(CH_LF);

		// Random phases. Each one rewrites the mask while idle and cycles through the
		// idling patterns: none, sender gaps, receiver stalls, and both at once.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_mask(masks[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 57;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 57;
				end
				default: begin
					send_idle_pct = 29;
					stall_pct <= 29;
				end
			endcase
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target) begin
				send_traffic();
				// Half way through, the sender holds off until the pipeline is empty.
				if (chars_sent >= target - PHASE_CHARS / 2
					&& chars_sent < target - PHASE_CHARS / 2 + 8)
					wait_drained();
			end
		end

		// Drain: every result must come back before the verdict.
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Sent %0d characters over %0d mask settings and four idling patterns.",
			chars_sent, PHASE_COUNT + 1);
		$display("Checked %0d results, %0d of them accepted sentences.", checked, sentences);
		if (fail_count == 0) begin
			$display("** nmea_sentence_framer_top: PASSED **");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("** nmea_sentence_framer_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== nmea_sentence_framer_top.f =====
rtl/core/nsf_pkg.sv
rtl/core/nsf_hdr_match.sv
rtl/core/nsf_line_state.sv
rtl/core/nmea_sentence_framer_top.sv
rtl/core/nsf_checker.sv
tb/nsf_framer_checker.sv
tb/nmea_sentence_framer_top_test.sv
